@@ src/cps_pkg.sv @@
// shared types, constants and tables for the particle to four-vector converter
package cps_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int EXP_TERMS    = 20;
  localparam int SQRT_STEPS   = 32;
  localparam int STEP_W       = 5;

  localparam logic        [29:0] LN2_Q30     = 30'd744261118;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic        [29:0] GAIN_Q30    = 30'd652032874;
  localparam logic        [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic        [31:0] MAX_S32     = 32'h7fff_ffff;

  localparam logic [2:0] TYPE_PHOTON   = 3'd0;
  localparam logic [2:0] TYPE_ELECTRON = 3'd1;
  localparam logic [2:0] TYPE_MUON     = 3'd2;
  localparam logic [2:0] TYPE_TAU      = 3'd3;
  localparam logic [2:0] TYPE_JET      = 3'd4;
  localparam logic [2:0] TYPE_MET      = 3'd5;

  localparam logic [1:0] BTAG_LOOSE = 2'd1;
  localparam logic [1:0] BTAG_TIGHT = 2'd2;

  localparam logic signed [18:0] PDG_PHOTON   = 19'sd22;
  localparam logic signed [18:0] PDG_ELECTRON = 19'sd11;
  localparam logic signed [18:0] PDG_MUON     = 19'sd13;
  localparam logic signed [18:0] PDG_TAU      = 19'sd15;
  localparam logic signed [18:0] PDG_BJET     = 19'sd55;
  localparam logic signed [18:0] PDG_JET      = 19'sd211234;
  localparam logic signed [18:0] PDG_MET      = 19'sd121416;

  typedef struct packed {
    logic signed [18:0] code;
    logic               bad;
    logic               neg;
    logic               eta_neg;
    logic        [19:0] pt;
    logic        [19:0] mass;
    logic signed [39:0] x;
    logic signed [39:0] y;
    logic signed [33:0] z;
    logic        [3:0]  k;
    logic        [29:0] r;
    logic        [30:0] term;
    logic        [29:0] prod;
    logic        [29:0] quo;
    logic        [31:0] ep;
    logic signed [32:0] em;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic        [30:0] pzm;
    logic        [43:0] s2;
    logic        [41:0] mlo;
    logic        [41:0] mhi;
    logic        [39:0] sq_pt;
    logic        [61:0] sq_pz;
    logic        [39:0] sq_m;
    logic        [63:0] rem;
    logic        [63:0] root;
  } cps_item_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // floor(2^32 / i) for the taylor term divisors
  function automatic logic [32:0] recip_q32(input logic [4:0] i);
    logic [32:0] v;
    case (i)
      5'd1:  v = 33'd4294967296;
      5'd2:  v = 33'd2147483648;
      5'd3:  v = 33'd1431655765;
      5'd4:  v = 33'd1073741824;
      5'd5:  v = 33'd858993459;
      5'd6:  v = 33'd715827882;
      5'd7:  v = 33'd613566756;
      5'd8:  v = 33'd536870912;
      5'd9:  v = 33'd477218588;
      5'd10: v = 33'd429496729;
      5'd11: v = 33'd390451572;
      5'd12: v = 33'd357913941;
      5'd13: v = 33'd330382099;
      5'd14: v = 33'd306783378;
      5'd15: v = 33'd286331153;
      5'd16: v = 33'd268435456;
      5'd17: v = 33'd252645135;
      5'd18: v = 33'd238609294;
      5'd19: v = 33'd226050910;
      default: v = 33'd0;
    endcase
    return v;
  endfunction

  function automatic logic [34:0] ln2_mul(input logic [3:0] m);
    return 35'(m) * 35'(LN2_Q30);
  endfunction

endpackage

@@ src/cps_cordic_cell.sv @@
// one rotation stage of the circular cordic
module cps_cordic_cell import cps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [STEP_W-1:0] step_idx,
  input  logic              vld_i,
  input  cps_item_t         item_i,
  output logic              vld_o,
  output cps_item_t         item_o
);

  cps_item_t         item_nxt;
  cps_item_t         item_r;
  logic              vld_r;
  logic signed [39:0] xs;
  logic signed [39:0] ys;
  logic signed [39:0] dx;
  logic signed [39:0] dy;
  logic signed [33:0] da;

  always_comb begin
    item_nxt = item_i;
    xs = item_i.x;
    ys = item_i.y;
    dx = ys >>> step_idx;
    dy = xs >>> step_idx;
    da = $signed({4'b0000, atan_q30(step_idx)});
    if (!item_i.z[33]) begin
      item_nxt.x = xs - dx;
      item_nxt.y = ys + dy;
      item_nxt.z = item_i.z - da;
    end else begin
      item_nxt.x = xs + dx;
      item_nxt.y = ys - dy;
      item_nxt.z = item_i.z + da;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;

endmodule

@@ src/cps_exp_cell.sv @@
// one taylor term of exp(r): multiply, reciprocal divide, correction
module cps_exp_cell import cps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [STEP_W-1:0] term_idx,
  input  logic              vld_i,
  input  cps_item_t         item_i,
  output logic              vld_o,
  output cps_item_t         item_o
);

  cps_item_t   a_nxt;
  cps_item_t   b_nxt;
  cps_item_t   c_nxt;
  cps_item_t   a_r;
  cps_item_t   b_r;
  cps_item_t   c_r;
  logic        a_vld_r;
  logic        b_vld_r;
  logic        c_vld_r;
  logic [60:0] mul_a;
  logic [62:0] mul_b;
  logic [32:0] recip;
  logic [34:0] back;
  logic [34:0] rem;
  logic [29:0] q;

  always_comb begin
    a_nxt = item_i;
    mul_a = 61'(item_i.term) * 61'(item_i.r);
    a_nxt.prod = mul_a[59:30];

    // quotient estimate is exact or one short
    b_nxt = a_r;
    recip = recip_q32(term_idx);
    mul_b = 63'(a_r.prod) * 63'(recip);
    b_nxt.quo = mul_b[61:32];

    c_nxt = b_r;
    back = 35'(b_r.quo) * 35'(term_idx);
    rem  = 35'(b_r.prod) - back;
    q    = (rem >= 35'(term_idx)) ? b_r.quo + 30'd1 : b_r.quo;
    c_nxt.term = {1'b0, q};
    c_nxt.ep   = b_r.ep + 32'(q);
    // odd terms enter exp(-r) negated
    if (term_idx[0]) begin
      c_nxt.em = b_r.em - $signed(33'(q));
    end else begin
      c_nxt.em = b_r.em + $signed(33'(q));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= vld_i;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
    if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
  end

  assign vld_o  = c_vld_r;
  assign item_o = c_r;

endmodule

@@ src/cps_sqrt_cell.sv @@
// one result bit of the integer square root
module cps_sqrt_cell import cps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [STEP_W-1:0] step_idx,
  input  logic              vld_i,
  input  cps_item_t         item_i,
  output logic              vld_o,
  output cps_item_t         item_o
);

  cps_item_t   item_nxt;
  cps_item_t   item_r;
  logic        vld_r;
  logic [63:0] bit_v;
  logic [63:0] trial;

  always_comb begin
    item_nxt = item_i;
    bit_v = 64'd1 << (6'd62 - {step_idx, 1'b0});
    trial = item_i.root + bit_v;
    if (item_i.rem >= trial) begin
      item_nxt.rem  = item_i.rem - trial;
      item_nxt.root = (item_i.root >> 1) + bit_v;
    end else begin
      item_nxt.root = item_i.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;

endmodule

@@ src/collider_particle_to_four_vector.sv @@
// top level: detector particle to particle code and four-momentum
//
// One request on the in_ channel carries one particle: type, eta (Q4.12),
// phi (Q3.13 rad), pt and mass in 1/16 GeV, signed track count and b-tag.
// Each request gives exactly one result on the out_ channel: particle code,
// px, py, pz, energy and a flag for an unknown type (all other fields 0).
// Both channels are valid/ready.
// The datapath is one pipeline of cells: an input stage, CORDIC_STEPS
// cordic rotation cells, 19 taylor-term cells of three stages each for
// exp(|eta|), five stages for sinh, pz and the squared momenta, 32 square
// root cells and the output register.
// A new request is taken every cycle while the output is not stalled;
// throughput is then one particle per cycle.
// The whole pipeline advances together: when out_valid is high and
// out_ready low, every stage holds and in_ready drops in the same cycle,
// and it rises again in the cycle the result is taken.
// Reset clears every stage's valid bit; no request is lost or invented,
// and the block takes a request in the first cycle after reset.
module collider_particle_to_four_vector import cps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [2:0]  in_particle_type,
  input  logic signed [15:0] in_pseudorapidity,
  input  logic signed [15:0] in_azimuth,
  input  logic        [19:0] in_transverse_momentum,
  input  logic        [19:0] in_rest_mass,
  input  logic signed [8:0]  in_track_signed_count,
  input  logic        [1:0]  in_btag_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [18:0] out_pdg_code,
  output logic signed [31:0] out_mom_x,
  output logic signed [31:0] out_mom_y,
  output logic signed [31:0] out_mom_z,
  output logic        [31:0] out_total_energy,
  output logic               out_bad_type
);

  localparam int EXP_CELLS = EXP_TERMS - 1;

  logic adv;

  cps_item_t f_nxt;
  cps_item_t f_r;
  logic      f_vld_r;

  logic signed [34:0] z0;
  logic signed [34:0] z1;
  logic        [49:0] gain_prod;
  logic        [16:0] eta_abs;
  logic        [34:0] a_val;
  logic        [3:0]  k_val;
  logic               trk_pos;

  cps_item_t cor_item [CORDIC_STEPS+1];
  logic      cor_vld  [CORDIC_STEPS+1];
  cps_item_t exp_item [EXP_CELLS+1];
  logic      exp_vld  [EXP_CELLS+1];
  cps_item_t sq_item  [SQRT_STEPS+1];
  logic      sq_vld   [SQRT_STEPS+1];

  cps_item_t p1_nxt, p2_nxt, p3_nxt, p4_nxt, p5_nxt;
  cps_item_t p1_r, p2_r, p3_r, p4_r, p5_r;
  logic      p1_vld_r, p2_vld_r, p3_vld_r, p4_vld_r, p5_vld_r;

  logic signed [39:0] xs;
  logic signed [39:0] ys;
  logic        [31:0] emc;
  logic        [63:0] pz_sum;
  logic        [32:0] pz_full;
  logic        [30:0] pzm_c;

  logic               out_valid_r;
  logic signed [18:0] pdg_r;
  logic signed [31:0] mom_x_r;
  logic signed [31:0] mom_y_r;
  logic signed [31:0] mom_z_r;
  logic        [31:0] energy_r;
  logic               bad_r;
  cps_item_t          fin;

  function automatic logic signed [31:0] round_clamp(input logic signed [39:0] v,
                                                     input logic neg);
    logic signed [39:0] t;
    logic signed [31:0] res;
    t = (v + 40'sd32768) >>> 16;
    if (neg) begin
      t = -t;
    end
    if (t > 40'sd2147483647) begin
      res = $signed(MAX_S32);
    end else if (t < -40'sd2147483647) begin
      res = -$signed(MAX_S32);
    end else begin
      res = t[31:0];
    end
    return res;
  endfunction

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // input stage: code, angle folding, cordic seed, eta range reduction
  always_comb begin
    f_nxt = '0;
    trk_pos = !in_track_signed_count[8] && (in_track_signed_count != 9'sd0);
    f_nxt.bad = 1'b0;
    case (in_particle_type)
      TYPE_PHOTON:   f_nxt.code = PDG_PHOTON;
      TYPE_ELECTRON: f_nxt.code = trk_pos ? -PDG_ELECTRON : PDG_ELECTRON;
      TYPE_MUON:     f_nxt.code = trk_pos ? -PDG_MUON : PDG_MUON;
      TYPE_TAU:      f_nxt.code = trk_pos ? -PDG_TAU : PDG_TAU;
      TYPE_JET: begin
        if (in_btag_code == BTAG_TIGHT) begin
          f_nxt.code = PDG_BJET;
        end else if (in_btag_code == BTAG_LOOSE) begin
          f_nxt.code = -PDG_BJET;
        end else begin
          f_nxt.code = PDG_JET;
        end
      end
      TYPE_MET:      f_nxt.code = PDG_MET;
      default: begin
        f_nxt.code = '0;
        f_nxt.bad  = 1'b1;
      end
    endcase

    z0 = {{2{in_azimuth[15]}}, in_azimuth, 17'b0};
    z1 = z0;
    f_nxt.neg = 1'b0;
    if (z0 > HALF_PI_Q30) begin
      z1 = z0 - PI_Q30;
      f_nxt.neg = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      z1 = z0 + PI_Q30;
      f_nxt.neg = 1'b1;
    end
    f_nxt.z = z1[33:0];

    gain_prod = 50'(in_transverse_momentum) * 50'(GAIN_Q30);
    f_nxt.x = $signed({4'b0000, gain_prod[49:14]});
    f_nxt.y = '0;

    eta_abs = in_pseudorapidity[15] ? 17'(-{in_pseudorapidity[15], in_pseudorapidity})
                                    : {1'b0, in_pseudorapidity};
    a_val = {eta_abs, 18'b0};
    k_val = '0;
    for (int m = 1; m < 16; m++) begin
      if (a_val >= ln2_mul(4'(m))) begin
        k_val = 4'(m);
      end
    end
    f_nxt.k       = k_val;
    f_nxt.r       = 30'(a_val - ln2_mul(k_val));
    f_nxt.term    = Q30_ONE;
    f_nxt.ep      = 32'(Q30_ONE);
    f_nxt.em      = $signed(33'(Q30_ONE));
    f_nxt.eta_neg = in_pseudorapidity[15];
    f_nxt.pt      = in_transverse_momentum;
    f_nxt.mass    = in_rest_mass;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= in_valid;
    end
    if (adv) begin
      f_r <= f_nxt;
    end
  end

  assign cor_item[0] = f_r;
  assign cor_vld[0]  = f_vld_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    cps_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .step_idx (STEP_W'(g)),
      .vld_i    (cor_vld[g]),
      .item_i   (cor_item[g]),
      .vld_o    (cor_vld[g+1]),
      .item_o   (cor_item[g+1])
    );
  end

  assign exp_item[0] = cor_item[CORDIC_STEPS];
  assign exp_vld[0]  = cor_vld[CORDIC_STEPS];

  for (genvar g = 0; g < EXP_CELLS; g++) begin : g_exp
    cps_exp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .term_idx (STEP_W'(g + 1)),
      .vld_i    (exp_vld[g]),
      .item_i   (exp_item[g]),
      .vld_o    (exp_vld[g+1]),
      .item_o   (exp_item[g+1])
    );
  end

  // px/py rounding and 2*sinh|eta| in Q30
  always_comb begin
    p1_nxt = exp_item[EXP_CELLS];
    xs = p1_nxt.x;
    ys = p1_nxt.y;
    p1_nxt.px = round_clamp(xs, p1_nxt.neg);
    p1_nxt.py = round_clamp(ys, p1_nxt.neg);
    emc = p1_nxt.em[32] ? 32'd0 : p1_nxt.em[31:0];
    p1_nxt.s2 = ({12'b0, p1_nxt.ep} << p1_nxt.k) - ({12'b0, emc} >> p1_nxt.k);
  end

  // pt * s2 in two partial products
  always_comb begin
    p2_nxt = p1_r;
    p2_nxt.mlo = 42'(p1_r.pt) * 42'(p1_r.s2[21:0]);
    p2_nxt.mhi = 42'(p1_r.pt) * 42'(p1_r.s2[43:22]);
  end

  always_comb begin
    p3_nxt = p2_r;
    pz_sum = (64'(p2_r.mhi) << 22) + 64'(p2_r.mlo) + 64'(Q30_ONE);
    pz_full = pz_sum[63:31];
    pzm_c = (pz_full > 33'(MAX_S32)) ? MAX_S32[30:0] : pz_full[30:0];
    p3_nxt.pzm = pzm_c;
    p3_nxt.pz  = p2_r.eta_neg ? -$signed({1'b0, pzm_c}) : $signed({1'b0, pzm_c});
  end

  always_comb begin
    p4_nxt = p3_r;
    p4_nxt.sq_pt = 40'(p3_r.pt) * 40'(p3_r.pt);
    p4_nxt.sq_pz = 62'(p3_r.pzm) * 62'(p3_r.pzm);
    p4_nxt.sq_m  = 40'(p3_r.mass) * 40'(p3_r.mass);
  end

  always_comb begin
    p5_nxt = p4_r;
    p5_nxt.rem  = 64'(p4_r.sq_pt) + 64'(p4_r.sq_pz) + 64'(p4_r.sq_m);
    p5_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
      p5_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= exp_vld[EXP_CELLS];
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
      p5_vld_r <= p4_vld_r;
    end
    if (adv) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      p3_r <= p3_nxt;
      p4_r <= p4_nxt;
      p5_r <= p5_nxt;
    end
  end

  assign sq_item[0] = p5_r;
  assign sq_vld[0]  = p5_vld_r;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    cps_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .step_idx (STEP_W'(g)),
      .vld_i    (sq_vld[g]),
      .item_i   (sq_item[g]),
      .vld_o    (sq_vld[g+1]),
      .item_o   (sq_item[g+1])
    );
  end

  assign fin = sq_item[SQRT_STEPS];

  // output register; an unknown type reports all zeros
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sq_vld[SQRT_STEPS];
    end
    if (adv) begin
      bad_r <= fin.bad;
      if (fin.bad) begin
        pdg_r    <= '0;
        mom_x_r  <= '0;
        mom_y_r  <= '0;
        mom_z_r  <= '0;
        energy_r <= '0;
      end else begin
        pdg_r    <= fin.code;
        mom_x_r  <= fin.px;
        mom_y_r  <= fin.py;
        mom_z_r  <= fin.pz;
        energy_r <= (|fin.root[63:32]) ? 32'hffff_ffff : fin.root[31:0];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pdg_code     = pdg_r;
  assign out_mom_x        = mom_x_r;
  assign out_mom_y        = mom_y_r;
  assign out_mom_z        = mom_z_r;
  assign out_total_energy = energy_r;
  assign out_bad_type     = bad_r;

endmodule

@@ src/cps_checker.sv @@
// port-level checks for the particle to four-vector converter, with bind
module cps_checker import cps_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [18:0] out_pdg_code,
  input logic signed [31:0] out_mom_x,
  input logic signed [31:0] out_mom_y,
  input logic signed [31:0] out_mom_z,
  input logic        [31:0] out_total_energy,
  input logic               out_bad_type
);

  logic [31:0] pz_mag;

  assign pz_mag = out_mom_z[31] ? 32'(-out_mom_z) : 32'(out_mom_z);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mom_x) && $stable(out_mom_z)
      && $stable(out_total_energy) && $stable(out_pdg_code))
    else $error("stalled result changed");

  // input side stalls exactly when the result register is blocked
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_type |-> out_pdg_code == 19'sd0 && out_mom_x == 32'sd0
      && out_mom_y == 32'sd0 && out_mom_z == 32'sd0 && out_total_energy == 32'd0)
    else $error("unknown type result not cleared");

  a_energy_pz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_type |-> out_total_energy >= pz_mag)
    else $error("energy below longitudinal momentum");

endmodule

bind collider_particle_to_four_vector cps_checker u_cps_checker (.*);

@@ dv/collider_particle_to_four_vector_tb.sv @@
// testbench for the particle to four-vector converter: directed table, random streams, predictor
`timescale 1ns / 100ps

module collider_particle_to_four_vector_tb;
  import cps_pkg::*;

  typedef struct {
    logic signed [18:0] code;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
    logic        [31:0] en;
    logic               bad;
  } four_vec_t;

  typedef struct {
    logic        [2:0]  ty;
    logic signed [15:0] eta;
    logic signed [15:0] phi;
    logic        [19:0] pt;
    logic        [19:0] mass;
    logic signed [8:0]  ntrk;
    logic        [1:0]  btag;
    bit                 known;
    four_vec_t          res;
  } particle_row_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = CORDIC_STEPS + 150;
  localparam longint unsigned SAT_U32 = 64'hffff_ffff;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic        [2:0]  in_particle_type;
  logic signed [15:0] in_pseudorapidity, in_azimuth;
  logic        [19:0] in_transverse_momentum, in_rest_mass;
  logic signed [8:0]  in_track_signed_count;
  logic        [1:0]  in_btag_code;
  logic signed [18:0] out_pdg_code;
  logic signed [31:0] out_mom_x, out_mom_y, out_mom_z;
  logic        [31:0] out_total_energy;
  logic               out_bad_type;

  four_vec_t    pending_q[$];
  four_vec_t    typed_res;
  bit           typed_known;
  particle_row_t rows[$];
  int errors = 0, n_in = 0, n_out = 0, n_bad = 0, idle_cycles = 0;
  int idle_pct = 0, stall_pct = 0;

  collider_particle_to_four_vector dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0, bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483647) return -64'sd2147483647;
    return v;
  endfunction

  function automatic four_vec_t predict_four_vector(
      logic [2:0] ty, logic signed [15:0] eta, logic signed [15:0] phi,
      logic [19:0] pt, logic [19:0] mass, logic signed [8:0] ntrk, logic [1:0] btag);
    four_vec_t r;
    longint z, x, y, dx, dy, px, py, pz, em;
    longint unsigned a, k, rr, term, ep, s2, pzm, e, p2, ptl, ml;
    bit neg;
    r = '{default: '0};
    case (ty)
      TYPE_PHOTON:   r.code = PDG_PHOTON;
      TYPE_ELECTRON: r.code = ntrk > 0 ? -PDG_ELECTRON : PDG_ELECTRON;
      TYPE_MUON:     r.code = ntrk > 0 ? -PDG_MUON : PDG_MUON;
      TYPE_TAU:      r.code = ntrk > 0 ? -PDG_TAU : PDG_TAU;
      TYPE_JET:      r.code = btag == BTAG_TIGHT ? PDG_BJET :
                              (btag == BTAG_LOOSE ? -PDG_BJET : PDG_JET);
      TYPE_MET:      r.code = PDG_MET;
      default: begin
        r.bad = 1'b1;
        return r;
      end
    endcase
    ptl = pt;
    ml  = mass;
    // fold phi into [-pi/2, pi/2], negating the vector
    z = longint'(phi) * 131072;
    neg = 1'b0;
    if (z > longint'(HALF_PI_Q30)) begin
      z -= longint'(PI_Q30);
      neg = 1'b1;
    end else if (z < -longint'(HALF_PI_Q30)) begin
      z += longint'(PI_Q30);
      neg = 1'b1;
    end
    x = longint'((ptl * 64'd652032874) >> 14);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> (i % 32);
      dy = x >>> (i % 32);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
      end
    end
    px = (x + 32768) >>> 16;
    py = (y + 32768) >>> 16;
    if (neg) begin
      px = -px;
      py = -py;
    end
    r.mx = 32'(clamp_s32(px));
    r.my = 32'(clamp_s32(py));
    // exp(|eta|) = 2^k * exp(r)
    a  = longint'(eta < 0 ? -longint'(eta) : longint'(eta)) << 18;
    k  = a / 64'd744261118;
    rr = a - k * 64'd744261118;
    term = 64'd1 << 30;
    ep = term;
    em = longint'(term);
    for (int i = 1; i < EXP_TERMS; i++) begin
      term = ((term * rr) >> 30) / longint'(i);
      ep += term;
      if (i % 2) em -= longint'(term);
      else em += longint'(term);
    end
    if (em < 0) em = 0;
    s2  = (ep << (k & 15)) - (longint'(em) >> (k & 15));
    pzm = (ptl * s2 + (64'd1 << 30)) >> 31;
    if (pzm > 64'd2147483647) pzm = 64'd2147483647;
    pz  = eta < 0 ? -longint'(pzm) : longint'(pzm);
    r.mz = 32'(pz);
    p2 = ptl * ptl + pzm * pzm + ml * ml;
    e  = int_sqrt(p2);
    if (e > SAT_U32) e = SAT_U32;
    r.en = 32'(e);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("mismatch on result %0d, %s: got %0d, expected %0d", n_out, field, got, want);
  endtask

  // requests in, results out, scoreboard and watchdog
  always @(posedge clk) begin
    four_vec_t w;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        n_in++;
        pending_q.push_back(typed_known ? typed_res : predict_four_vector(
            in_particle_type, in_pseudorapidity, in_azimuth, in_transverse_momentum,
            in_rest_mass, in_track_signed_count, in_btag_code));
      end
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          errors++;
          $display("result %0d arrived with nothing pending", n_out);
        end else begin
          w = pending_q.pop_front();
          if (out_pdg_code !== w.code) report_mismatch("pdg_code", out_pdg_code, w.code);
          if (out_mom_x !== w.mx) report_mismatch("mom_x", out_mom_x, w.mx);
          if (out_mom_y !== w.my) report_mismatch("mom_y", out_mom_y, w.my);
          if (out_mom_z !== w.mz) report_mismatch("mom_z", out_mom_z, w.mz);
          if (out_total_energy !== w.en)
            report_mismatch("total_energy", out_total_energy, w.en);
          if (out_bad_type !== w.bad) report_mismatch("bad_type", out_bad_type, w.bad);
          if (w.bad) n_bad++;
        end
        n_out++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (!in_valid && pending_q.size() == 0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_particle(particle_row_t p);
    in_valid               <= 1'b1;
    in_particle_type       <= p.ty;
    in_pseudorapidity      <= p.eta;
    in_azimuth             <= p.phi;
    in_transverse_momentum <= p.pt;
    in_rest_mass           <= p.mass;
    in_track_signed_count  <= p.ntrk;
    in_btag_code           <= p.btag;
    typed_known            <= p.known;
    typed_res              <= p.res;
    do @(posedge clk); while (!in_ready);
    // each following cycle is idle with probability idle_pct
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic add_row(logic [2:0] ty, int eta, int phi, int pt, int mass, int ntrk,
                         int btag, bit known, four_vec_t res);
    particle_row_t p;
    p = '{ty: ty, eta: 16'(eta), phi: 16'(phi), pt: 20'(pt), mass: 20'(mass),
          ntrk: 9'(ntrk), btag: 2'(btag), known: known, res: res};
    rows.push_back(p);
  endtask

  function automatic particle_row_t random_particle();
    particle_row_t p;
    p.ty   = ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
    p.eta  = 16'($urandom);
    p.phi  = 16'($urandom);
    p.pt   = $urandom_range(3) == 0 ? 20'($urandom_range(255)) : 20'($urandom);
    p.mass = $urandom_range(1) ? 20'($urandom_range(4095)) : 20'($urandom);
    p.ntrk = 9'($urandom_range(510) - 255);
    p.btag = 2'($urandom);
    p.known = 1'b0;
    p.res = '{default: '0};
    return p;
  endfunction

  initial begin
    four_vec_t none, inval, at_rest;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_particle_type = '0;
    in_pseudorapidity = '0;
    in_azimuth = '0;
    in_transverse_momentum = '0;
    in_rest_mass = '0;
    in_track_signed_count = '0;
    in_btag_code = '0;
    typed_known = 1'b0;
    typed_res = '{default: '0};
    none  = '{default: '0};
    inval = '{default: '0};
    inval.bad = 1'b1;

    // unknown types: everything zero, flag set
    add_row(3'd6, 32767, -32768, 1048575, 1048575, 255, 3, 1, inval);
    add_row(3'd7, -32768, 32767, 0, 0, -255, 0, 1, inval);
    // zero pt: no momentum, energy is the mass
    at_rest = '{code: PDG_PHOTON, mx: 0, my: 0, mz: 0, en: 32'd1048575, bad: 0};
    add_row(TYPE_PHOTON, 32767, 32767, 0, 1048575, 0, 0, 1, at_rest);
    at_rest = '{code: PDG_JET, mx: 0, my: 0, mz: 0, en: 32'd0, bad: 0};
    add_row(TYPE_JET, -32768, -32768, 0, 0, 0, 3, 1, at_rest);
    at_rest = '{code: PDG_MET, mx: 0, my: 0, mz: 0, en: 32'd100, bad: 0};
    add_row(TYPE_MET, 0, 0, 0, 100, 0, 0, 1, at_rest);
    // leptons with positive, zero and negative track counts
    add_row(TYPE_ELECTRON, 4096, 6434, 16000, 8, 1, 0, 0, none);
    add_row(TYPE_ELECTRON, -4096, -6434, 16000, 8, 0, 0, 0, none);
    add_row(TYPE_MUON, 32767, 12868, 1048575, 0, 255, 1, 0, none);
    add_row(TYPE_MUON, -32768, -12868, 1048575, 1048575, -255, 2, 0, none);
    add_row(TYPE_TAU, 0, 25736, 5000, 28, -1, 0, 0, none);
    add_row(TYPE_TAU, 100, -25736, 5000, 28, 2, 3, 0, none);
    // every b-tag code on a jet
    add_row(TYPE_JET, 8192, 32767, 800000, 20000, 10, 0, 0, none);
    add_row(TYPE_JET, -8192, -32768, 800000, 20000, 10, 1, 0, none);
    add_row(TYPE_JET, 1, 1, 1, 1, 10, 2, 0, none);
    add_row(TYPE_JET, -1, -1, 1048575, 1048575, -256, 3, 0, none);
    add_row(TYPE_PHOTON, 32767, 0, 1048575, 1048575, 0, 0, 0, none);
    add_row(TYPE_MET, -32768, 12867, 1048575, 0, 0, 0, 0, none);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) send_particle(rows[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      for (int n = 0; n < 150; n++) begin
        send_particle(random_particle());
        if (ph == 1 && n == 75) begin
          // hold off until the pipeline has fully drained
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_q.size() != 0) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d particles sent, %0d results checked, %0d with unknown type",
             n_in, n_out, n_bad);
    $display("phases: free flow, sender gaps, receiver stalls, mixed; one full drain");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
